### design/dfe_pkg.sv
package dfe_pkg;

   localparam int MAX_PATTERN  = 8;
   localparam int FRAME_BYTES  = 18;
   localparam int WINDOW_DEPTH = FRAME_BYTES + MAX_PATTERN;
   localparam int WORD_COUNT   = FRAME_BYTES / 2;
   localparam int COUNT_W      = 5;
   localparam int LEN_W        = 4;
   localparam int LANE_W       = $clog2(MAX_PATTERN);

   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   typedef logic [WINDOW_DEPTH-1:0][7:0] window_type;
   typedef logic [WORD_COUNT-1:0][15:0]  words_type;
   typedef logic [COUNT_W-1:0]           count_type;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES = 2'd0,
      REG_PATTERN_LEN   = 2'd1,
      REG_BIG_ENDIAN    = 2'd2
   } reg_index_type;

   // Live configuration; len is already clamped to 1..MAX_PATTERN
   typedef struct packed {
      logic [63:0]      pattern;
      logic [LEN_W-1:0] len;
      logic             big_endian;
   } cfg_type;

   typedef struct packed {
      logic delim;
      logic emit;
   } match_type;

endpackage

### design/dfe_csr.sv
module dfe_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready,
   output dfe_pkg::cfg_type  cfg
);

   logic [63:0]               pattern_ff;
   logic [dfe_pkg::LEN_W-1:0] len_ff;
   logic                      big_endian_ff;
   logic                      wr_en;
   dfe_pkg::reg_index_type    index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = dfe_pkg::reg_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff    <= 64'd0;
         len_ff        <= 4'd1;
         big_endian_ff <= 1'b0;
      end else if (wr_en) begin
         case (index)
            dfe_pkg::REG_PATTERN_BYTES: pattern_ff    <= pwdata;
            dfe_pkg::REG_PATTERN_LEN:   len_ff        <= pwdata[3:0];
            dfe_pkg::REG_BIG_ENDIAN:    big_endian_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         dfe_pkg::REG_PATTERN_BYTES: prdata = pattern_ff;
         dfe_pkg::REG_PATTERN_LEN:   prdata = {60'd0, len_ff};
         dfe_pkg::REG_BIG_ENDIAN:    prdata = {63'd0, big_endian_ff};
         default:                    prdata = 64'd0;
      endcase
   end

   // clamp length: zero acts as one, beyond the window limit saturates
   always_comb begin
      cfg.pattern    = pattern_ff;
      cfg.big_endian = big_endian_ff;
      if (len_ff == 4'd0) begin
         cfg.len = 4'd1;
      end else if (len_ff > 4'(dfe_pkg::MAX_PATTERN)) begin
         cfg.len = 4'(dfe_pkg::MAX_PATTERN);
      end else begin
         cfg.len = len_ff;
      end
   end

endmodule

### design/dfe_window.sv
module dfe_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                pop,
   input  logic                delim,
   input  logic [7:0]          in_byte,
   output dfe_pkg::window_type win,
   output dfe_pkg::count_type  count,
   output logic                busy
);

   dfe_pkg::window_type win_ff;
   dfe_pkg::count_type  count_ff;
   dfe_pkg::count_type  base;
   logic                busy_ff;

   assign win   = win_ff;
   assign count = count_ff;
   assign busy  = busy_ff;

   // drop the count to zero once the held item turns out to close a delimiter
   assign base = (pop && delim) ? '0 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else if (accept) begin
         win_ff   <= {win_ff[dfe_pkg::WINDOW_DEPTH-2:0], in_byte};
         count_ff <= (base == dfe_pkg::COUNT_MAX) ? base : base + 5'd1;
         busy_ff  <= 1'b1;
      end else if (pop) begin
         count_ff <= base;
         busy_ff  <= 1'b0;
      end
   end

endmodule

### design/dfe_match.sv
module dfe_match (
   input  dfe_pkg::cfg_type    cfg,
   input  dfe_pkg::window_type win,
   input  dfe_pkg::count_type  count,
   output dfe_pkg::match_type  status,
   output dfe_pkg::words_type  words
);

   logic [dfe_pkg::MAX_PATTERN-1:0] lane_hit;
   logic [dfe_pkg::LEN_W-1:0]       len_m1;
   logic [dfe_pkg::LANE_W-1:0]      lane;
   logic                            count_ok;
   logic                            long_enough;
   dfe_pkg::window_type             shifted;
   logic [7:0]                      first;
   logic [7:0]                      second;

   // one lane per candidate length, newest byte at index 0
   always_comb begin
      lane_hit = '1;
      for (int l = 1; l <= dfe_pkg::MAX_PATTERN; l++) begin
         for (int i = 0; i < l; i++) begin
            if (win[l-1-i] != cfg.pattern[8*i +: 8]) begin
               lane_hit[l-1] = 1'b0;
            end
         end
      end
   end

   assign len_m1      = cfg.len - 4'd1;
   assign lane        = len_m1[dfe_pkg::LANE_W-1:0];
   assign count_ok    = count >= {1'b0, cfg.len};
   assign long_enough = count >= ({1'b0, cfg.len} + 5'(dfe_pkg::FRAME_BYTES));

   assign status.delim = count_ok && lane_hit[lane];
   assign status.emit  = status.delim && long_enough;

   // skip the delimiter bytes, the frame then sits at the bottom
   assign shifted = win >> {cfg.len, 3'b000};

   always_comb begin
      first  = 8'd0;
      second = 8'd0;
      for (int k = 0; k < dfe_pkg::WORD_COUNT; k++) begin
         first  = shifted[dfe_pkg::FRAME_BYTES-1-2*k];
         second = shifted[dfe_pkg::FRAME_BYTES-2-2*k];
         words[k] = cfg.big_endian ? {first, second} : {second, first};
      end
   end

endmodule

### design/delimited_frame_extractor.sv
// Delimiter-based deframer for a sensor byte stream. Bytes enter on the req_ channel
// (valid/stall) one per cycle, and one item may be accepted every cycle while req_stall
// is low; each byte is registered in the window stage, where a parallel compare of the
// newest pattern_len bytes against the configured delimiter decides the match.
// A delimiter that does not overlap the previous one and has at least 18 bytes
// before it yields one rsp_ item of nine signed 16-bit words, built from the 18
// bytes just before the delimiter (word0 from the oldest pair). The last
// delimiter byte is registered in the window stage, and its frame then loads into the
// result register, which drives rsp_valid. The only backpressure comes
// from the result register: a byte completing a frame is held while the previous
// frame is still stalled on the output. Registers sit on an APB port at byte
// addresses 0 (pattern_bytes, 64 bits, first delimiter byte in bits 7:0), 8
// (pattern_len, zero acts as 1, values above 8 act as 8) and 16 (big_endian);
// write them only while the block is idle.
module delimited_frame_extractor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_word0,
   output logic signed [15:0] rsp_word1,
   output logic signed [15:0] rsp_word2,
   output logic signed [15:0] rsp_word3,
   output logic signed [15:0] rsp_word4,
   output logic signed [15:0] rsp_word5,
   output logic signed [15:0] rsp_word6,
   output logic signed [15:0] rsp_word7,
   output logic signed [15:0] rsp_word8,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   dfe_pkg::cfg_type    cfg;
   dfe_pkg::window_type win;
   dfe_pkg::count_type  count;
   dfe_pkg::match_type  status;
   dfe_pkg::words_type  words;
   dfe_pkg::words_type  words_ff;
   logic                busy;
   logic                out_free;
   logic                pop;
   logic                accept;
   logic                rsp_valid_ff;

   dfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Window stage: holds the byte just taken, the shifted window and the count.
   dfe_window u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .pop     (pop),
      .delim   (status.delim),
      .in_byte (req_in_byte),
      .win     (win),
      .count   (count),
      .busy    (busy)
   );

   // Compare and frame extraction on the registered window.
   dfe_match u_match (
      .cfg    (cfg),
      .win    (win),
      .count  (count),
      .status (status),
      .words  (words)
   );

   // The result register can take a new frame when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The held byte leaves the window stage unless it carries a frame with
   // nowhere to go; a byte without a frame never waits.
   assign pop       = busy && (!status.emit || out_free);
   assign req_stall = busy && status.emit && !out_free;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && status.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload: load a frame, otherwise hold.
   always_ff @(posedge clock) begin
      if (pop && status.emit) begin
         words_ff <= words;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word0 = $signed(words_ff[0]);
   assign rsp_word1 = $signed(words_ff[1]);
   assign rsp_word2 = $signed(words_ff[2]);
   assign rsp_word3 = $signed(words_ff[3]);
   assign rsp_word4 = $signed(words_ff[4]);
   assign rsp_word5 = $signed(words_ff[5]);
   assign rsp_word6 = $signed(words_ff[6]);
   assign rsp_word7 = $signed(words_ff[7]);
   assign rsp_word8 = $signed(words_ff[8]);

endmodule

### dv/delimited_frame_extractor_tb.sv
module delimited_frame_extractor_tb;

   localparam int           CLOCK_PERIOD  = 12;
   localparam int           RUN_LIMIT     = CLOCK_PERIOD * 400000;
   localparam int           ITEM_TARGET   = 1050;
   localparam int           PHASE_ITEMS   = 130;
   localparam int           SETTLE_CYCLES = 4;
   localparam int           REPORT_LIMIT  = 10;

   // Byte addresses of the registers; the unmapped one must be ignored
   localparam logic [4:0]   PATTERN_ADDR  = {dfe_pkg::REG_PATTERN_BYTES, 3'd0};
   localparam logic [4:0]   LEN_ADDR      = {dfe_pkg::REG_PATTERN_LEN, 3'd0};
   localparam logic [4:0]   ENDIAN_ADDR   = {dfe_pkg::REG_BIG_ENDIAN, 3'd0};
   localparam logic [4:0]   UNMAPPED_ADDR = 5'd24;

   typedef enum logic {STEP_BYTE, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type       kind;
      logic [4:0]          addr;
      logic [63:0]         data;
      logic [7:0]          value;
      bit                  typed;
      dfe_pkg::words_type  words;
   } script_step_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_in_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_word0;
   logic signed [15:0] rsp_word1;
   logic signed [15:0] rsp_word2;
   logic signed [15:0] rsp_word3;
   logic signed [15:0] rsp_word4;
   logic signed [15:0] rsp_word5;
   logic signed [15:0] rsp_word6;
   logic signed [15:0] rsp_word7;
   logic signed [15:0] rsp_word8;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [4:0]         paddr;
   logic [63:0]        pwdata;
   logic [63:0]        prdata;
   logic               pready;

   // Shadow of the deframer: registers, byte window and gap count
   logic [63:0]                delim_pattern;
   logic [dfe_pkg::LEN_W-1:0]  delim_len_raw;
   logic                       pair_big_endian;
   dfe_pkg::window_type        recent_bytes;
   dfe_pkg::count_type         since_delim;

   // Frames predicted but not yet seen on the result channel
   dfe_pkg::words_type frames_due[$];

   // Directed rows, walked in order after reset
   script_step_type    script[$];

   // Typed expectation that travels with a directed byte
   bit                 row_typed;
   dfe_pkg::words_type row_words;

   int                 fail_count;
   int                 frame_index;
   int                 sent;
   int                 burst_left;
   logic [15:0]        stall_bits;
   logic [3:0]         stall_pos;

   delimited_frame_extractor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word0   (rsp_word0),
      .rsp_word1   (rsp_word1),
      .rsp_word2   (rsp_word2),
      .rsp_word3   (rsp_word3),
      .rsp_word4   (rsp_word4),
      .rsp_word5   (rsp_word5),
      .rsp_word6   (rsp_word6),
      .rsp_word7   (rsp_word7),
      .rsp_word8   (rsp_word8),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #(RUN_LIMIT);
      $display("[delimited_frame_extractor] ERROR");
      $finish;
   end

   // Length in use: zero acts as one, anything above the window limit saturates
   function automatic int clamp_len(input logic [dfe_pkg::LEN_W-1:0] raw);
      if (raw == 0)
         return 1;
      if (raw > dfe_pkg::MAX_PATTERN)
         return dfe_pkg::MAX_PATTERN;
      return int'(raw);
   endfunction

   // Append one directed row
   function automatic void add_step(input step_kind_type kind, input logic [4:0] addr,
                                    input logic [63:0] data, input logic [7:0] value,
                                    input bit typed, input dfe_pkg::words_type words);
      script_step_type step;
      step.kind  = kind;
      step.addr  = addr;
      step.data  = data;
      step.value = value;
      step.typed = typed;
      step.words = words;
      script.insert(script.size(), step);
   endfunction

   // Advance the shadow deframer by one byte; report a frame when a delimiter
   // with a full frame in front of it completes on this byte
   task automatic deframe_byte(input logic [7:0] value, output bit emit,
                               output dfe_pkg::words_type words);
      int          len;
      bit          hit;
      logic [7:0]  first;
      logic [7:0]  second;
      len   = clamp_len(delim_len_raw);
      emit  = 1'b0;
      words = '0;
      recent_bytes = {recent_bytes[dfe_pkg::WINDOW_DEPTH-2:0], value};
      if (since_delim < dfe_pkg::COUNT_MAX)
         since_delim = since_delim + 1'b1;
      // Newest byte sits at index 0, so the first delimiter byte is len-1 back
      hit = (since_delim >= len);
      for (int i = 0; i < len; i++) begin
         if (recent_bytes[len-1-i] != delim_pattern[8*i +: 8])
            hit = 1'b0;
      end
      if (hit) begin
         if (since_delim - len >= dfe_pkg::FRAME_BYTES) begin
            emit = 1'b1;
            for (int k = 0; k < dfe_pkg::WORD_COUNT; k++) begin
               first  = recent_bytes[len + dfe_pkg::FRAME_BYTES - 1 - 2*k];
               second = recent_bytes[len + dfe_pkg::FRAME_BYTES - 2 - 2*k];
               words[k] = pair_big_endian ? {first, second} : {second, first};
            end
         end
         since_delim = '0;
      end
   endtask

   task automatic flag_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   // Sample everything at the rising edge: check results first, then track
   // register writes and advance the shadow on every accepted byte
   always @(posedge clock) begin
      bit                 emit;
      dfe_pkg::words_type fresh;
      dfe_pkg::words_type seen;
      dfe_pkg::words_type due;
      if (reset) begin
         delim_pattern   = '0;
         delim_len_raw   = 4'd1;
         pair_big_endian = 1'b0;
         recent_bytes    = '0;
         since_delim     = '0;
         frames_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_word8, rsp_word7, rsp_word6, rsp_word5, rsp_word4,
                    rsp_word3, rsp_word2, rsp_word1, rsp_word0};
            if (frames_due.size() == 0) begin
               flag_failure($sformatf("frame %0d: unexpected, got %h", frame_index, seen));
            end else begin
               due = frames_due.pop_front();
               for (int k = 0; k < dfe_pkg::WORD_COUNT; k++) begin
                  if (seen[k] !== due[k])
                     flag_failure($sformatf("frame %0d word%0d: expected %h, got %h",
                                            frame_index, k, due[k], seen[k]));
               end
            end
            frame_index++;
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               dfe_pkg::REG_PATTERN_BYTES: delim_pattern   = pwdata;
               dfe_pkg::REG_PATTERN_LEN:   delim_len_raw   = pwdata[dfe_pkg::LEN_W-1:0];
               dfe_pkg::REG_BIG_ENDIAN:    pair_big_endian = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_in_byte, emit, fresh);
            if (row_typed)
               frames_due.insert(frames_due.size(), row_words);
            else if (emit)
               frames_due.insert(frames_due.size(), fresh);
         end
      end
   end

   // Receiver: replay a 16-bit stall word, redrawn each time it runs out
   always @(negedge clock) begin
      if (stall_pos == 0) begin
         case ($urandom_range(3))
            0: stall_bits = 16'h0000;
            1: stall_bits = 16'($urandom);
            2: stall_bits = 16'($urandom) & 16'($urandom);
            default: stall_bits = 16'hFFF0;
         endcase
      end
      rsp_stall <= stall_bits[stall_pos];
      stall_pos = stall_pos + 1'b1;
   end

   // Offer one byte and hold it until accepted; open a random gap between bursts
   task automatic push_byte(input logic [7:0] value, input bit typed = 1'b0,
                            input dfe_pkg::words_type words = '0);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      row_typed   <= typed;
      row_words   <= words;
      burst_left--;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // Drop valid, drain the result channel, then let the window stage empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [4:0] addr, input logic [63:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly plain random bytes, with the sign and range extremes mixed in
   function automatic logic [7:0] sample_byte();
      case ($urandom_range(15))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      logic [63:0]  pat;
      logic [3:0]   raw_len;
      logic         be;
      int           eff;
      int           pick;
      int           payload;
      int           target;
      int           phase;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = '0;
      rsp_stall   = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      row_typed   = 1'b0;
      row_words   = '0;
      fail_count  = 0;
      frame_index = 0;
      sent        = 0;
      burst_left  = 0;
      stall_bits  = '0;
      stall_pos   = '0;

      // Reset values: the delimiter is a single zero byte, little endian.
      // Eighteen 0xFF bytes and a zero close a full frame of all-ones words.
      for (int i = 0; i < dfe_pkg::FRAME_BYTES; i++)
         add_step(STEP_BYTE, 5'd0, 64'd0, 8'hFF, 1'b0, '0);
      add_step(STEP_BYTE, 5'd0, 64'd0, 8'h00, 1'b1, '1);
      // Short frame: delimiter after one byte clears the count, no result
      add_step(STEP_BYTE, 5'd0, 64'd0, 8'h80, 1'b0, '0);
      add_step(STEP_BYTE, 5'd0, 64'd0, 8'h00, 1'b0, '0);
      // Unmapped register write must leave the configuration alone
      add_step(STEP_CSR, UNMAPPED_ADDR, '1, 8'h00, 1'b0, '0);
      add_step(STEP_CSR, LEN_ADDR, 64'd2, 8'h00, 1'b0, '0);
      add_step(STEP_CSR, ENDIAN_ADDR, 64'd1, 8'h00, 1'b0, '0);
      // Two-zero delimiter over a run of zeros: the third zero overlaps the
      // previous delimiter and must not match, the fourth does
      for (int i = 0; i < 4; i++)
         add_step(STEP_BYTE, 5'd0, 64'd0, 8'h00, 1'b0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR) begin
            settle();
            csr_write(script[i].addr, script[i].data);
         end else begin
            push_byte(script[i].value, script[i].typed, script[i].words);
         end
      end

      // Random phases: walk a fixed set of settings, extremes included, and
      // keep going until enough bytes have passed
      phase = 0;
      while (sent < ITEM_TARGET) begin
         case (phase % 8)
            0: begin pat = '1;                    raw_len = 4'd8;  be = 1'b0; end
            1: begin pat = '0;                    raw_len = 4'd15; be = 1'b1; end
            2: begin pat = {$urandom, $urandom};  raw_len = 4'd0;  be = 1'b1; end
            3: begin pat = {$urandom, $urandom};  raw_len = 4'd1;  be = 1'b0; end
            4: begin pat = {$urandom, $urandom};  raw_len = 4'd9;  be = 1'b1; end
            5: begin pat = {$urandom, $urandom};  raw_len = 4'd3;  be = 1'b0; end
            6: begin pat = {$urandom, $urandom};  raw_len = 4'd5;  be = 1'b1; end
            default: begin pat = {$urandom, $urandom}; raw_len = 4'd2; be = 1'b0; end
         endcase
         settle();
         csr_write(PATTERN_ADDR, pat);
         // Upper data bits are don't-care; toggle them anyway
         csr_write(LEN_ADDR, {$urandom, 15'($urandom_range(0, 15'h7FFF)), 13'd0, raw_len});
         csr_write(ENDIAN_ADDR, {$urandom, 31'($urandom), be});
         eff    = clamp_len(raw_len);
         target = sent + PHASE_ITEMS;
         while (sent < target && sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
               // Well-formed frame, sometimes long or short, then the delimiter
               case ($urandom_range(19))
                  0, 1, 2:  payload = $urandom_range(0, dfe_pkg::FRAME_BYTES - 1);
                  3, 4, 5:  payload = $urandom_range(dfe_pkg::FRAME_BYTES + 1,
                                                     dfe_pkg::FRAME_BYTES + 10);
                  default:  payload = dfe_pkg::FRAME_BYTES;
               endcase
               repeat (payload) push_byte(sample_byte());
               for (int i = 0; i < eff; i++)
                  push_byte(pat[8*i +: 8]);
            end else if (pick < 90) begin
               // Broken delimiter: corrupt its last byte
               repeat (dfe_pkg::FRAME_BYTES) push_byte(sample_byte());
               for (int i = 0; i < eff - 1; i++)
                  push_byte(pat[8*i +: 8]);
               push_byte(~pat[8*(eff-1) +: 8]);
            end else begin
               // Noise burst; the longer ones drive the count into saturation
               repeat ($urandom_range(1, 45)) push_byte(sample_byte());
            end
         end
         phase++;
      end

      settle();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[delimited_frame_extractor] OK");
      else
         $display("[delimited_frame_extractor] ERROR");
      $finish;
   end

endmodule

### delimited_frame_extractor.f
design/dfe_pkg.sv
design/dfe_csr.sv
design/dfe_window.sv
design/dfe_match.sv
design/delimited_frame_extractor.sv
dv/delimited_frame_extractor_tb.sv
